FILE: hw/rtl/rng_pkg.sv
package rng_pkg;

  // Item kinds on the input tuser bit
  typedef enum logic {
    CMD_POLL    = 1'b0,
    CMD_CAPTURE = 1'b1
  } cmd_t;

  // Per-channel ranging phase
  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_MEASURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DIST_W  = 11;
  localparam int unsigned GAP_W   = 8;

  localparam logic [GAP_W-1:0] GAP_RESET = 8'd25;

  // echo / 58 == (echo >> 1) / 29 == ((echo >> 1) * RECIP) >> RECIP_SHIFT
  // exact for every 15-bit operand (error term 9 * 32767 < 2^24 / 29)
  localparam int unsigned HALF_W      = TICK_W - 1;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP = 20'd578525;
  localparam int unsigned PROD_W      = HALF_W + RECIP_W;

  // Result of the state update stage, before the distance is worked out
  typedef struct packed {
    logic              trig_fire;
    logic [CHAN_W-1:0] trig_channel;
    logic              meas_valid;
    logic [CHAN_W-1:0] meas_channel;
    logic [TICK_W-1:0] echo_us;
    logic              edge_falling;
  } stage_t;

endpackage

FILE: hw/rtl/rng_ctrl.sv
module rng_ctrl #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rng_pkg::GAP_W-1:0]          cfg_wr_data,
  input  logic                               take,
  input  logic                               load,
  input  logic                               in_valid,
  input  rng_pkg::cmd_t                      in_cmd,
  input  logic [rng_pkg::NOW_W-1:0]          in_now,
  input  logic [rng_pkg::CHAN_W-1:0]         in_cch,
  input  logic [rng_pkg::TICK_W-1:0]         in_cval,
  output logic                               s1_valid,
  output rng_pkg::stage_t                    s1_data
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [rng_pkg::GAP_W-1:0]   settle_r;
  logic [IDX_W-1:0]            cur_r, cur_nxt;
  rng_pkg::phase_t             phase_r [NUM_CHANNELS];
  rng_pkg::phase_t             phase_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     armed_r, armed_nxt;
  logic [NUM_CHANNELS-1:0]     first_r, first_nxt;
  logic [rng_pkg::TICK_W-1:0]  rise_r [NUM_CHANNELS];
  logic [rng_pkg::TICK_W-1:0]  rise_nxt [NUM_CHANNELS];
  logic [rng_pkg::NOW_W-1:0]   gap_start_r, gap_start_nxt;
  logic                        gap_run_r, gap_run_nxt;
  logic                        s1_valid_r;
  rng_pkg::stage_t             s1_r, res;

  logic [rng_pkg::NOW_W-1:0]   gap_diff;
  logic                        gap_expired;
  logic [IDX_W-1:0]            cur_next_idx;

  assign gap_diff     = in_now - gap_start_r;
  assign gap_expired  = gap_run_r &&
                        (gap_diff > {{(rng_pkg::NOW_W-rng_pkg::GAP_W){1'b0}}, settle_r});
  assign cur_next_idx = (cur_r == IDX_W'(NUM_CHANNELS - 1)) ? '0 : cur_r + 1'b1;

  always_comb begin
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    armed_nxt     = armed_r;
    first_nxt     = first_r;
    rise_nxt      = rise_r;
    gap_start_nxt = gap_start_r;
    gap_run_nxt   = gap_run_r;
    res           = '0;
    if (take) begin
      if (in_cmd == rng_pkg::CMD_POLL) begin
        case (phase_r[cur_r])
          rng_pkg::PH_TRIGGER: begin
            // fire the trigger and arm the capture
            res.trig_fire      = 1'b1;
            res.trig_channel   = rng_pkg::CHAN_W'(cur_r);
            armed_nxt[cur_r]   = 1'b1;
            phase_nxt[cur_r]   = rng_pkg::PH_MEASURE;
          end
          rng_pkg::PH_DONE: begin
            if (!gap_run_r) begin
              gap_start_nxt = in_now;
              gap_run_nxt   = 1'b1;
            end
            if (gap_expired) begin
              phase_nxt[cur_r] = rng_pkg::PH_TRIGGER;
              cur_nxt          = cur_next_idx;
              gap_run_nxt      = 1'b0;
            end
          end
          default: ;
        endcase
      end else begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (int'(in_cch) == i && armed_r[i]) begin
            if (!first_r[i]) begin
              rise_nxt[i]      = in_cval;
              first_nxt[i]     = 1'b1;
              res.edge_falling = 1'b1;
            end else begin
              first_nxt[i]     = 1'b0;
              armed_nxt[i]     = 1'b0;
              phase_nxt[i]     = rng_pkg::PH_DONE;
              res.meas_valid   = 1'b1;
              res.meas_channel = in_cch;
              res.echo_us      = in_cval - rise_r[i];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= rng_pkg::GAP_RESET;
      cur_r      <= '0;
      armed_r    <= '0;
      first_r    <= '0;
      gap_run_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_r[i] <= rng_pkg::PH_TRIGGER;
      end
    end else begin
      if (cfg_wr_en) begin
        settle_r <= cfg_wr_data;
      end
      cur_r     <= cur_nxt;
      phase_r   <= phase_nxt;
      armed_r   <= armed_nxt;
      first_r   <= first_nxt;
      gap_run_r <= gap_run_nxt;
      if (load) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    rise_r      <= rise_nxt;
    gap_start_r <= gap_start_nxt;
    if (load) begin
      s1_r <= res;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_r;

  // An armed channel is always the one waiting for its echo
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chk
    a_armed_measure: assert property (@(posedge clk) disable iff (!rst_n)
      armed_r[g] == (phase_r[g] == rng_pkg::PH_MEASURE))
      else $error("capture arm out of step with phase");
    a_first_armed: assert property (@(posedge clk) disable iff (!rst_n)
      first_r[g] |-> armed_r[g])
      else $error("rising edge held on a disarmed channel");
  end

  a_gap_done: assert property (@(posedge clk) disable iff (!rst_n)
    gap_run_r |-> (phase_r[cur_r] == rng_pkg::PH_DONE))
    else $error("settle gap running outside done phase");

endmodule

FILE: hw/rtl/rng_dist.sv
module rng_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  rng_pkg::stage_t             s1_data,
  output logic                        s2_en,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rng_pkg::stage_t             out_data,
  output logic [rng_pkg::DIST_W-1:0]  out_dist
);

  logic                          out_valid_r;
  rng_pkg::stage_t               out_data_r;
  logic [rng_pkg::DIST_W-1:0]    out_dist_r;
  logic [rng_pkg::PROD_W-1:0]    prod;

  // echo / 58 through the halved operand and a reciprocal
  assign prod = {{rng_pkg::RECIP_W{1'b0}}, s1_data.echo_us[rng_pkg::TICK_W-1:1]}
              * {{rng_pkg::HALF_W{1'b0}}, rng_pkg::RECIP};

  // advance when the output register is empty or being drained
  assign s2_en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      out_data_r <= s1_data;
      out_dist_r <= prod[rng_pkg::RECIP_SHIFT +: rng_pkg::DIST_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_dist  = out_dist_r;

endmodule

FILE: hw/rtl/multi_channel_ultrasonic_ranger.sv
// An accepted item is registered in the state update stage, then in the
// divide-by-58 output stage before its result reaches out_*. Throughput:
// 1 item per cycle; in_tready drops only when both hold and out_* stalls.
// Reset: synchronous, active-low rst_n; all channels go to trigger phase,
// captures disarm, channel 0 becomes current and the settle gap is 25 ms.
module multi_channel_ultrasonic_ranger #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: settle gap in milliseconds
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] cmd: 0 poll, 1 capture
  input  logic [55:0] in_tdata,   // [31:0] now_ms, [33:32] capture_channel,
                                  // [49:34] capture_value, [55:50] zero
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [0] trig_fire, [1] meas_valid
  output logic [31:0] out_tdata   // [1:0] trig_channel, [3:2] meas_channel,
                                  // [19:4] echo_us, [30:20] range_cm,
                                  // [31] edge_falling
);

  logic                          take;
  logic                          s1_valid;
  logic                          s2_en;
  rng_pkg::stage_t               s1_data;
  rng_pkg::stage_t               res;
  logic [rng_pkg::DIST_W-1:0]    range_cm;
  rng_pkg::cmd_t                 in_cmd;

  // The state stage may load whenever its register is empty or moves on
  assign in_tready = !s1_valid || s2_en;
  assign take      = in_tvalid && in_tready;
  assign in_cmd    = rng_pkg::cmd_t'(in_tuser);

  // Channel state, settle gap timing and the echo width
  rng_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .load        (in_tready),
    .in_valid    (in_tvalid),
    .in_cmd      (in_cmd),
    .in_now      (in_tdata[31:0]),
    .in_cch      (in_tdata[33:32]),
    .in_cval     (in_tdata[49:34]),
    .s1_valid    (s1_valid),
    .s1_data     (s1_data)
  );

  // Distance from the echo width, held in the output register
  rng_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s2_en     (s2_en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res),
    .out_dist  (range_cm)
  );

  // Pack the result item
  assign out_tuser = {res.meas_valid, res.trig_fire};
  assign out_tdata = {res.edge_falling, range_cm, res.echo_us, res.meas_channel,
                      res.trig_channel};

endmodule

FILE: sim/tb_multi_channel_ultrasonic_ranger.sv
`timescale 1ns / 1ps

module tb_multi_channel_ultrasonic_ranger;

  localparam int NUM_CH        = 3;
  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int MAX_REPORTS   = 10;
  localparam int TAIL_CYCLES   = 10;    // idle tail after all results have arrived

  // One result item, unpacked into its fields
  typedef struct packed {
    logic                       trig_fire;
    logic [rng_pkg::CHAN_W-1:0] trig_channel;
    logic                       meas_valid;
    logic [rng_pkg::CHAN_W-1:0] meas_channel;
    logic [rng_pkg::TICK_W-1:0] echo_us;
    logic [rng_pkg::DIST_W-1:0] range_cm;
    logic                       edge_falling;
  } ranging_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;   // [0] cmd
  logic [55:0] in_tdata;   // [31:0] now_ms, [33:32] capture_channel, [49:34] capture_value
  logic        out_tvalid;
  logic        out_tready;
  logic [1:0]  out_tuser;  // [0] trig_fire, [1] meas_valid
  logic [31:0] out_tdata;  // [1:0] trig_channel, [3:2] meas_channel, [19:4] echo_us,
                           // [30:20] range_cm, [31] edge_falling

  multi_channel_ultrasonic_ranger #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Ranger state as the block should hold it
  logic [rng_pkg::GAP_W-1:0]  settle_ms;
  logic [rng_pkg::CHAN_W-1:0] cur_chan;
  rng_pkg::phase_t            chan_phase [NUM_CH];
  logic                       armed      [NUM_CH];
  logic                       rise_seen  [NUM_CH];
  logic [rng_pkg::TICK_W-1:0] rise_stamp [NUM_CH];
  logic [rng_pkg::NOW_W-1:0]  gap_origin;
  logic                       gap_active;

  // Results predicted for accepted items, oldest first
  ranging_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int stall_cycles;
  logic [rng_pkg::NOW_W-1:0] clock_ms;   // running millisecond time for well-formed polls

  int n_items, n_polls, n_captures, n_triggers, n_measurements, n_advances, n_ignored;

  always #(CLK_HALF_NS) clk = ~clk;

  // Work out the result of one item and advance the ranger state
  function automatic ranging_result_t predict_ranging(
    rng_pkg::cmd_t              cmd,
    logic [rng_pkg::NOW_W-1:0]  now,
    logic [rng_pkg::CHAN_W-1:0] chan,
    logic [rng_pkg::TICK_W-1:0] stamp
  );
    ranging_result_t            r;
    int                         c;
    logic [rng_pkg::NOW_W-1:0]  elapsed;
    logic [rng_pkg::TICK_W-1:0] span;
    r = '0;
    if (cmd == rng_pkg::CMD_POLL) begin
      n_polls++;
      c = cur_chan;
      if (chan_phase[c] == rng_pkg::PH_TRIGGER) begin
        r.trig_fire    = 1'b1;
        r.trig_channel = rng_pkg::CHAN_W'(c);
        armed[c]       = 1'b1;
        chan_phase[c]  = rng_pkg::PH_MEASURE;
        n_triggers++;
      end else if (chan_phase[c] == rng_pkg::PH_DONE) begin
        if (!gap_active) begin
          gap_origin = now;
          gap_active = 1'b1;
        end
        elapsed = now - gap_origin;
        if (elapsed > rng_pkg::NOW_W'(settle_ms)) begin
          chan_phase[c] = rng_pkg::PH_TRIGGER;
          cur_chan      = rng_pkg::CHAN_W'((c + 1) % NUM_CH);
          gap_active    = 1'b0;
          n_advances++;
        end
      end
    end else begin
      n_captures++;
      // drop captures for channels that do not exist or are not armed
      if (chan >= NUM_CH || !armed[chan]) begin
        n_ignored++;
      end else if (!rise_seen[chan]) begin
        rise_stamp[chan] = stamp;
        rise_seen[chan]  = 1'b1;
        r.edge_falling   = 1'b1;
      end else begin
        span             = stamp - rise_stamp[chan];
        rise_seen[chan]  = 1'b0;
        chan_phase[chan] = rng_pkg::PH_DONE;
        armed[chan]      = 1'b0;
        r.meas_valid     = 1'b1;
        r.meas_channel   = chan;
        r.echo_us        = span;
        r.range_cm       = rng_pkg::DIST_W'(span / 16'd58);
        n_measurements++;
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Drive one item, hold it until accepted, then record its expected result
  task automatic send_item(input rng_pkg::cmd_t cmd,
                           input logic [rng_pkg::NOW_W-1:0] now,
                           input logic [rng_pkg::CHAN_W-1:0] chan,
                           input logic [rng_pkg::TICK_W-1:0] stamp);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, stamp, chan, now};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_ranging(cmd, now, chan, stamp));
    n_items++;
  endtask

  // Stop sending and hold off until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called while the block is idle
  task automatic write_settle_gap(input logic [rng_pkg::GAP_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
    settle_ms = value;
  endtask

  // Mostly well-formed ranging cycles driven from the predicted state,
  // with some stray polls and captures mixed in
  task automatic drive_ranging_traffic(input int count);
    int                         c;
    logic [rng_pkg::TICK_W-1:0] span;
    for (int k = 0; k < count; k++) begin
      c = cur_chan;
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1) == 0)
          send_item(rng_pkg::CMD_POLL,
                    ($urandom_range(3) == 0) ? rng_pkg::NOW_W'($urandom) : clock_ms,
                    rng_pkg::CHAN_W'($urandom_range(0, 3)), rng_pkg::TICK_W'($urandom));
        else
          send_item(rng_pkg::CMD_CAPTURE, rng_pkg::NOW_W'($urandom),
                    rng_pkg::CHAN_W'($urandom_range(0, 3)), rng_pkg::TICK_W'($urandom));
      end else begin
        case (chan_phase[c])
          rng_pkg::PH_TRIGGER: begin
            send_item(rng_pkg::CMD_POLL, clock_ms, rng_pkg::CHAN_W'($urandom_range(0, 3)),
                      rng_pkg::TICK_W'($urandom));
          end
          rng_pkg::PH_MEASURE: begin
            if (!rise_seen[c]) begin
              send_item(rng_pkg::CMD_CAPTURE, rng_pkg::NOW_W'($urandom),
                        rng_pkg::CHAN_W'(c), rng_pkg::TICK_W'($urandom));
            end else begin
              case ($urandom_range(3))
                0:       span = rng_pkg::TICK_W'($urandom_range(0, 200));
                1:       span = rng_pkg::TICK_W'($urandom_range(0, 30000));
                default: span = rng_pkg::TICK_W'($urandom);
              endcase
              send_item(rng_pkg::CMD_CAPTURE, rng_pkg::NOW_W'($urandom),
                        rng_pkg::CHAN_W'(c), rise_stamp[c] + span);
            end
          end
          default: begin
            // advance time, now and then jump anywhere (wraps included)
            if ($urandom_range(39) == 0) clock_ms = rng_pkg::NOW_W'($urandom);
            else clock_ms = clock_ms +
                            rng_pkg::NOW_W'($urandom_range(0, int'(settle_ms) / 4 + 3));
            send_item(rng_pkg::CMD_POLL, clock_ms, rng_pkg::CHAN_W'($urandom_range(0, 3)),
                      rng_pkg::TICK_W'($urandom));
          end
        endcase
      end
    end
  endtask

  // Hand-picked corners at the reset gap of 25 ms
  task automatic test_directed_corners();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd1, 16'hFFFF);  // disarmed channel
    send_item(rng_pkg::CMD_CAPTURE, 32'hFFFFFFFF, 2'd3, 16'h0000);  // no such channel
    send_item(rng_pkg::CMD_POLL,    32'hFFFFFFF0, 2'd0, 16'h0);     // fire channel 0
    send_item(rng_pkg::CMD_POLL,    32'h0,        2'd3, 16'hFFFF);  // measuring: no effect
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd0, 16'h0000);  // rising edge
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd2, 16'h1234);  // other channel
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd0, 16'hFFFF);  // widest echo
    send_item(rng_pkg::CMD_POLL,    32'hFFFFFFF0, 2'd0, 16'h0);     // gap starts
    send_item(rng_pkg::CMD_POLL,    32'h00000009, 2'd0, 16'h0);     // 25 across wrap: hold
    send_item(rng_pkg::CMD_POLL,    32'h0000000A, 2'd0, 16'h0);     // 26: go to channel 1
    send_item(rng_pkg::CMD_POLL,    32'hFFFFFFFF, 2'd0, 16'h0);     // fire channel 1
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd1, 16'hFFFF);
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd1, 16'h0000);  // timer wrap: echo of 1
    send_item(rng_pkg::CMD_POLL,    32'd100,      2'd0, 16'h0);
    send_item(rng_pkg::CMD_POLL,    32'd99,       2'd0, 16'h0);     // time went back
    send_item(rng_pkg::CMD_POLL,    32'd0,        2'd0, 16'h0);     // fire channel 2
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd2, 16'h1234);
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd2, 16'h1234);  // equal edges
    send_item(rng_pkg::CMD_CAPTURE, 32'h0,        2'd2, 16'h5555);  // disarmed again
    send_item(rng_pkg::CMD_POLL,    32'd0,        2'd0, 16'h0);
    send_item(rng_pkg::CMD_POLL,    32'd26,       2'd0, 16'h0);     // back to channel 0
    wait_for_results();
  endtask

  // Zero and full-scale settle gap
  task automatic test_gap_extremes();
    write_settle_gap(8'd0);
    drive_ranging_traffic(150);
    wait_for_results();
    write_settle_gap(8'd255);
    drive_ranging_traffic(150);
    wait_for_results();
  endtask

  task automatic test_random_mix(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wait_for_results();
    write_settle_gap(($urandom_range(1) == 0) ? rng_pkg::GAP_W'($urandom_range(0, 40))
                                              : rng_pkg::GAP_W'($urandom));
    drive_ranging_traffic(count);
    wait_for_results();
  endtask

  // Receiver: stall at random on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    ranging_result_t got;
    ranging_result_t want;
    string           msg;
    if (rst_n && out_tvalid && out_tready) begin
      got.trig_fire    = out_tuser[0];
      got.meas_valid   = out_tuser[1];
      got.trig_channel = out_tdata[1:0];
      got.meas_channel = out_tdata[3:2];
      got.echo_us      = out_tdata[19:4];
      got.range_cm     = out_tdata[30:20];
      got.edge_falling = out_tdata[31];
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result tuser=%b tdata=%h", out_tuser, out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.trig_fire !== want.trig_fire || got.trig_channel !== want.trig_channel ||
            got.meas_valid !== want.meas_valid || got.meas_channel !== want.meas_channel ||
            got.echo_us !== want.echo_us || got.range_cm !== want.range_cm ||
            got.edge_falling !== want.edge_falling) begin
          msg = $sformatf("exp trig=%b/%0d meas=%b/%0d echo=%0d range=%0d fall=%b",
                          want.trig_fire, want.trig_channel, want.meas_valid,
                          want.meas_channel, want.echo_us, want.range_cm,
                          want.edge_falling);
          msg = {msg, $sformatf(", got trig=%b/%0d meas=%b/%0d echo=%0d range=%0d fall=%b",
                                got.trig_fire, got.trig_channel, got.meas_valid,
                                got.meas_channel, got.echo_us, got.range_cm,
                                got.edge_falling)};
          note_failure(msg);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tuser      = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count    = 0;
    stall_cycles  = 0;
    n_items = 0; n_polls = 0; n_captures = 0; n_triggers = 0;
    n_measurements = 0; n_advances = 0; n_ignored = 0;
    settle_ms  = rng_pkg::GAP_RESET;
    cur_chan   = '0;
    gap_origin = '0;
    gap_active = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_phase[i] = rng_pkg::PH_TRIGGER;
      armed[i]      = 1'b0;
      rise_seen[i]  = 1'b0;
      rise_stamp[i] = '0;
    end
    clock_ms = rng_pkg::NOW_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_corners();
    send_idle_pct = 15;
    recv_idle_pct = 81;
    test_gap_extremes();
    test_random_mix(15, 81, 400);
    test_random_mix(81, 15, 400);
    test_random_mix(0, 0, 400);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run covered %0d items: %0d polls, %0d captures (%0d ignored).",
             n_items, n_polls, n_captures, n_ignored);
    $display("%0d triggers, %0d measurements, %0d channel advances; gap 25, 0, 255, random.",
             n_triggers, n_measurements, n_advances);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rng_pkg.sv
hw/rtl/rng_ctrl.sv
hw/rtl/rng_dist.sv
hw/rtl/multi_channel_ultrasonic_ranger.sv
sim/tb_multi_channel_ultrasonic_ranger.sv
